// ===== hdl/rlpl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpl_pkg
// Shared constants and types of the route lookup unit: table depth, command
// codes, the write broadcast and the search token that walks the cell chain.
// ----------------------------------------------------------------------------
package rlpl_pkg;

  // table depth, one cell per route entry
  localparam int ROUTE_ENTRIES = 64;

  // width of the entry_index field
  localparam int ENTRY_IDX_W = 6;

  // bits needed to number every cell
  localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

  // width used to compare a write slot against a cell number
  localparam int CELL_W = (IDX_W > ENTRY_IDX_W) ? IDX_W : ENTRY_IDX_W;

  // command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  // write broadcast to all cells
  typedef struct packed {
    logic              vld;
    logic [CELL_W-1:0] idx;
    logic [31:0]       net;
    logic [31:0]       mask;
    logic [15:0]       metric;
    logic [7:0]        intf;
    logic              up;
  } wr_t;

  // search token payload, best route so far
  typedef struct packed {
    logic [31:0] addr;
    logic        have;
    logic [31:0] mask;
    logic [15:0] metric;
    logic [7:0]  intf;
  } srch_t;

endpackage

// ===== hdl/rlpl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpl_cell
// One route entry plus one stage of the search chain. The cell stores its
// entry on a matching write and updates the passing token when its entry is
// a better match than the best one seen so far.
// ----------------------------------------------------------------------------
module rlpl_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [rlpl_pkg::CELL_W-1:0]  cell_idx_i,
  input  rlpl_pkg::wr_t                wr_i,
  input  logic                         tok_vld_i,
  input  rlpl_pkg::srch_t              tok_i,
  output logic                         tok_vld_o,
  output rlpl_pkg::srch_t              tok_o
);
  import rlpl_pkg::*;

  logic        valid_q;
  logic [31:0] net_q;
  logic [31:0] mask_q;
  logic [15:0] metric_q;
  logic [7:0]  intf_q;
  logic        wr_hit;
  logic        hit;
  logic        better;
  logic        tok_vld_q;
  srch_t       tok_d;
  srch_t       tok_q;

  assign wr_hit = wr_i.vld && (wr_i.idx == cell_idx_i);

  // entry valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_hit) begin
      valid_q <= wr_i.up;
    end
  end

  // entry payload, stored even when the entry is marked down
  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      net_q    <= wr_i.net;
      mask_q   <= wr_i.mask;
      metric_q <= wr_i.metric;
      intf_q   <= wr_i.intf;
    end
  end

  // match and preference: larger mask, then lower metric, earlier cell on ties
  assign hit    = valid_q && ((tok_i.addr & mask_q) == net_q);
  assign better = !tok_i.have || (mask_q > tok_i.mask) ||
                  ((mask_q == tok_i.mask) && (metric_q < tok_i.metric));

  always_comb begin
    tok_d = tok_i;
    if (hit && better) begin
      tok_d.have   = 1'b1;
      tok_d.mask   = mask_q;
      tok_d.metric = metric_q;
      tok_d.intf   = intf_q;
    end
  end

  // token stage toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule

// ===== hdl/route_longest_prefix_lookup_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_longest_prefix_lookup_unit
// Route table with longest-prefix lookup, built as a chain of entry cells.
// ----------------------------------------------------------------------------
// A write transfer stores one route entry and returns a zero result; another
// transfer may follow it, subject to the stall rule below. A lookup
// transfer sends a search token down the chain of ROUTE_ENTRIES cells, one
// cell per cycle, and no new item is taken until its result reaches the
// output register. A write is held off while an earlier result still waits
// on a stalled output; a lookup is taken then, and its result is parked
// until the output frees.
// ----------------------------------------------------------------------------
module route_longest_prefix_lookup_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [5:0]  entry_index_i,
  input  logic [31:0] entry_net_i,
  input  logic [31:0] entry_mask_i,
  input  logic [15:0] entry_metric_i,
  input  logic [7:0]  entry_intf_i,
  input  logic        entry_up_i,
  input  logic [31:0] lookup_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        match_found_o,
  output logic [7:0]  out_intf_o
);
  import rlpl_pkg::*;

  logic   in_acc;
  logic   wr_acc;
  logic   lk_acc;
  logic   out_free;
  logic   busy_q;
  logic   busy_d;
  logic   out_vld_q;
  logic   out_vld_d;
  logic   out_found_q;
  logic   out_found_d;
  logic [7:0] out_intf_q;
  logic [7:0] out_intf_d;
  logic   hold_vld_q;
  logic   hold_vld_d;
  logic   hold_found_q;
  logic [7:0] hold_intf_q;
  logic   tail_vld;
  logic   tail_found;
  logic [7:0] tail_intf;
  wr_t    wr;
  logic   tok_vld [ROUTE_ENTRIES+1];
  srch_t  tok     [ROUTE_ENTRIES+1];

  // input handshake
  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = busy_q || (out_vld_q && out_stall_i && (cmd_i == CMD_WRITE));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_acc     = in_acc && (cmd_i == CMD_WRITE);
  assign lk_acc     = in_acc && (cmd_i == CMD_LOOKUP);

  // write broadcast
  always_comb begin
    wr.vld    = wr_acc;
    wr.idx    = CELL_W'(entry_index_i);
    wr.net    = entry_net_i;
    wr.mask   = entry_mask_i;
    wr.metric = entry_metric_i;
    wr.intf   = entry_intf_i;
    wr.up     = entry_up_i;
  end

  // fresh token at the chain head
  assign tok_vld[0] = lk_acc;
  always_comb begin
    tok[0].addr   = lookup_addr_i;
    tok[0].have   = 1'b0;
    tok[0].mask   = '0;
    tok[0].metric = '0;
    tok[0].intf   = '0;
  end

  // cell chain
  for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
    rlpl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CELL_W'(i)),
      .wr_i       (wr),
      .tok_vld_i  (tok_vld[i]),
      .tok_i      (tok[i]),
      .tok_vld_o  (tok_vld[i+1]),
      .tok_o      (tok[i+1])
    );
  end

  // chain tail result
  assign tail_vld   = tok_vld[ROUTE_ENTRIES];
  assign tail_found = tok[ROUTE_ENTRIES].have;
  assign tail_intf  = tok[ROUTE_ENTRIES].have ? tok[ROUTE_ENTRIES].intf : 8'd0;

  // output register, hold stage and busy flag
  always_comb begin
    out_vld_d   = out_free ? 1'b0 : out_vld_q;
    out_found_d = out_found_q;
    out_intf_d  = out_intf_q;
    hold_vld_d  = hold_vld_q;
    busy_d      = busy_q;
    if (lk_acc) begin
      busy_d = 1'b1;
    end
    if (wr_acc) begin
      out_vld_d   = 1'b1;
      out_found_d = 1'b0;
      out_intf_d  = 8'd0;
    end else if (hold_vld_q && out_free) begin
      out_vld_d   = 1'b1;
      out_found_d = hold_found_q;
      out_intf_d  = hold_intf_q;
      hold_vld_d  = 1'b0;
      busy_d      = 1'b0;
    end else if (tail_vld && out_free) begin
      out_vld_d   = 1'b1;
      out_found_d = tail_found;
      out_intf_d  = tail_intf;
      busy_d      = 1'b0;
    end else if (tail_vld) begin
      hold_vld_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      out_vld_q  <= out_vld_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_intf_q  <= out_intf_d;
    if (tail_vld) begin
      hold_found_q <= tail_found;
      hold_intf_q  <= tail_intf;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign match_found_o = out_found_q;
  assign out_intf_o    = out_intf_q;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the route longest-prefix lookup unit. Route writes
// and address lookups go in through the input channel. A local copy of the
// route table predicts each result: largest mask first, then lowest metric,
// then lowest slot. A checker compares every output transfer with the
// oldest prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import rlpl_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  // one input item, every field present
  typedef struct {
    logic        cmd;
    logic [5:0]  idx;
    logic [31:0] net;
    logic [31:0] mask;
    logic [15:0] metric;
    logic [7:0]  intf;
    logic        up;
    logic [31:0] addr;
  } route_item_t;

  // one result item
  typedef struct packed {
    logic       found;
    logic [7:0] intf;
  } route_res_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        cmd_i          = CMD_LOOKUP;
  logic [5:0]  entry_index_i  = '0;
  logic [31:0] entry_net_i    = '0;
  logic [31:0] entry_mask_i   = '0;
  logic [15:0] entry_metric_i = '0;
  logic [7:0]  entry_intf_i   = '0;
  logic        entry_up_i     = 1'b0;
  logic [31:0] lookup_addr_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic        match_found_o;
  logic [7:0]  out_intf_o;

  // shadow route table
  logic [31:0] shadow_net    [ROUTE_ENTRIES];
  logic [31:0] shadow_mask   [ROUTE_ENTRIES];
  logic [15:0] shadow_metric [ROUTE_ENTRIES];
  logic [7:0]  shadow_intf   [ROUTE_ENTRIES];
  logic        shadow_valid  [ROUTE_ENTRIES];

  route_res_t  pending_routes[$];
  route_res_t  head_route;
  int          err_cnt        = 0;
  int          cyc_cnt        = 0;
  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;

  route_longest_prefix_lookup_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .entry_index_i  (entry_index_i),
    .entry_net_i    (entry_net_i),
    .entry_mask_i   (entry_mask_i),
    .entry_metric_i (entry_metric_i),
    .entry_intf_i   (entry_intf_i),
    .entry_up_i     (entry_up_i),
    .lookup_addr_i  (lookup_addr_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .match_found_o  (match_found_o),
    .out_intf_o     (out_intf_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // random output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  // apply one accepted item to the shadow table, return the expected result
  function automatic route_res_t resolve_route(route_item_t it);
    route_res_t  res;
    logic [31:0] best_mask;
    logic [15:0] best_metric;
    res = '0;
    best_mask = '0;
    best_metric = '0;
    if (it.cmd == CMD_WRITE) begin
      if (int'(it.idx) < ROUTE_ENTRIES) begin
        shadow_net[it.idx]    = it.net;
        shadow_mask[it.idx]   = it.mask;
        shadow_metric[it.idx] = it.metric;
        shadow_intf[it.idx]   = it.intf;
        shadow_valid[it.idx]  = it.up;
      end
      return res;
    end
    // scan in slot order, strict compares keep the lowest slot on full ties
    for (int i = 0; i < ROUTE_ENTRIES; i++) begin
      if (shadow_valid[i] && ((it.addr & shadow_mask[i]) == shadow_net[i])) begin
        if (!res.found || shadow_mask[i] > best_mask ||
            (shadow_mask[i] == best_mask && shadow_metric[i] < best_metric)) begin
          res.found   = 1'b1;
          res.intf    = shadow_intf[i];
          best_mask   = shadow_mask[i];
          best_metric = shadow_metric[i];
        end
      end
    end
    return res;
  endfunction

  // drive one item, hold it until the transfer, then record the prediction
  task automatic send_item(input route_item_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= it.cmd;
    entry_index_i  <= it.idx;
    entry_net_i    <= it.net;
    entry_mask_i   <= it.mask;
    entry_metric_i <= it.metric;
    entry_intf_i   <= it.intf;
    entry_up_i     <= it.up;
    lookup_addr_i  <= it.addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_routes.push_back(resolve_route(it));
  endtask

  // route write, lookup field filled with noise
  task automatic send_write(input logic [5:0] idx, input logic [31:0] net,
                            input logic [31:0] mask, input logic [15:0] metric,
                            input logic [7:0] intf, input logic up);
    route_item_t it;
    it.cmd    = CMD_WRITE;
    it.idx    = idx;
    it.net    = net;
    it.mask   = mask;
    it.metric = metric;
    it.intf   = intf;
    it.up     = up;
    it.addr   = $urandom;
    send_item(it);
  endtask

  // lookup, write fields filled with noise
  task automatic send_lookup(input logic [31:0] addr);
    route_item_t it;
    it.cmd    = CMD_LOOKUP;
    it.idx    = 6'($urandom);
    it.net    = $urandom;
    it.mask   = $urandom;
    it.metric = 16'($urandom);
    it.intf   = 8'($urandom);
    it.up     = 1'($urandom);
    it.addr   = addr;
    send_item(it);
  endtask

  // compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_routes.size() == 0) begin
        $error("unexpected result: match_found %0d out_intf 0x%02h",
               match_found_o, out_intf_o);
        err_cnt++;
      end else begin
        head_route = pending_routes.pop_front();
        if (match_found_o !== head_route.found) begin
          $error("match_found: expected %0d, actual %0d", head_route.found,
                 match_found_o);
          err_cnt++;
        end
        if (out_intf_o !== head_route.intf) begin
          $error("out_intf: expected 0x%02h, actual 0x%02h", head_route.intf,
                 out_intf_o);
          err_cnt++;
        end
      end
    end
  end

  // lookups into a table with nothing valid
  task automatic test_empty_table();
    send_lookup(32'h0000_0000);
    send_lookup(32'hFFFF_FFFF);
  endtask

  // longest mask, then lowest metric, then lowest slot
  task automatic test_prefix_priority();
    send_write(6'd63, 32'h0000_0000, 32'h0000_0000, 16'hFFFF, 8'h11, 1'b1);
    send_lookup(32'hFFFF_FFFF);
    send_write(6'd0, 32'h0A00_0000, 32'hFF00_0000, 16'd100, 8'h22, 1'b1);
    send_write(6'd1, 32'h0A01_0000, 32'hFFFF_0000, 16'd5, 8'h33, 1'b1);
    send_write(6'd2, 32'h0A01_0000, 32'hFFFF_0000, 16'd4, 8'h44, 1'b1);
    send_write(6'd3, 32'h0A01_0000, 32'hFFFF_0000, 16'd4, 8'h55, 1'b1);
    send_write(6'd4, 32'h0A01_0203, 32'hFFFF_FFFF, 16'd0, 8'hFF, 1'b1);
    send_lookup(32'h0A01_0203);
    send_lookup(32'h0A01_02FF);
    send_lookup(32'h0AFF_0000);
    send_lookup(32'h0B00_0000);
  endtask

  // invalidated slots, non-contiguous masks, losing the default route
  task automatic test_invalidate_and_odd_masks();
    send_write(6'd2, 32'h0A01_0000, 32'hFFFF_0000, 16'd4, 8'h44, 1'b0);
    send_lookup(32'h0A01_0900);
    send_write(6'd5, 32'h0012_0034, 32'h00FF_00FF, 16'd0, 8'h66, 1'b1);
    send_lookup(32'h0B12_0034);
    send_lookup(32'hAB12_CD34);
    send_write(6'd63, 32'h0000_0000, 32'h0000_0000, 16'hFFFF, 8'h11, 1'b0);
    send_lookup(32'h0B00_0000);
    send_lookup(32'h0A01_0203);
  endtask

  // random writes, half over four shared prefixes, lookups mostly aimed at live routes
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    logic [31:0] prefix_pool [4];
    logic [31:0] mask;
    logic [31:0] net;
    logic [15:0] metric;
    int          pfx;
    int          slot;
    int          live[$];
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    foreach (prefix_pool[k]) prefix_pool[k] = $urandom;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 40) begin
        pfx  = $urandom_range(0, 32);
        mask = 32'hFFFF_FFFF << (32 - pfx);
        if ($urandom_range(0, 9) == 0) mask = $urandom;
        net = $urandom_range(0, 1) ? prefix_pool[$urandom_range(0, 3)] : $urandom;
        if ($urandom_range(0, 9) != 0) net = net & mask;
        case ($urandom_range(0, 3))
          0: metric = 16'h0000;
          1: metric = 16'hFFFF;
          2: metric = 16'($urandom_range(0, 3));
          default: metric = 16'($urandom);
        endcase
        send_write(6'($urandom_range(0, 63)), net, mask, metric, 8'($urandom),
                   ($urandom_range(0, 99) < 85));
      end else begin
        live.delete();
        for (int i = 0; i < ROUTE_ENTRIES; i++) begin
          if (shadow_valid[i]) live.push_back(i);
        end
        if (live.size() != 0 && $urandom_range(0, 99) < 75) begin
          slot = live[$urandom_range(0, live.size() - 1)];
          send_lookup((shadow_net[slot] & shadow_mask[slot]) |
                      ($urandom & ~shadow_mask[slot]));
        end else if ($urandom_range(0, 1) == 0) begin
          send_lookup(prefix_pool[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(0, 31)));
        end else begin
          send_lookup($urandom);
        end
      end
    end
  endtask

  // main sequence
  initial begin
    for (int i = 0; i < ROUTE_ENTRIES; i++) shadow_valid[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct   = 30;
    sink_stall_pct = 50;
    test_empty_table();
    test_prefix_priority();
    test_invalidate_and_odd_masks();
    test_random_traffic(630, 30, 50);
    test_random_traffic(630, 50, 30);
    test_random_traffic(620, 0, 0);
    in_valid_i <= 1'b0;

    // drain, then watch for stray results
    while (pending_routes.size() != 0) @(posedge clk_i);
    repeat (ROUTE_ENTRIES + 8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rlpl_pkg.sv
hdl/rlpl_cell.sv
hdl/route_longest_prefix_lookup_unit.sv
bench/tb.sv
